[rtl/ntc_pkg.sv]
// Package: shared constants, types and the log table for the thermistor core.
`default_nettype none
package ntc_pkg;

  localparam int SAMPLES    = 10;
  localparam int ADC_BITS   = 10;
  localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
  localparam int FULL_SUM   = FULL_SCALE * SAMPLES;
  localparam int SUM_W      = 14;
  localparam int CNT_W      = 4;

  localparam int DIV_W      = 40;
  localparam int DIV_CNT_W  = 6;
  localparam int LNV_W      = 22;

  localparam int LN2_Q16     = 45426;
  localparam int KELVIN_CENT = 27315;
  localparam int OUT_MIN     = -50000;
  localparam int OUT_MAX     = 60000;

  localparam logic [1:0] CFG_BETA = 2'd0;
  localparam logic [1:0] CFG_T0   = 2'd1;
  localparam logic [1:0] CFG_UNIT = 2'd2;

  localparam logic [1:0] UNIT_KELVIN  = 2'd0;
  localparam logic [1:0] UNIT_CELSIUS = 2'd1;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ZERO = 2'd1;
  localparam logic [1:0] FAULT_FULL = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic start;
    logic [31:0] x;
  } ln_req_t;

  // ln(1 + i/16) in Q16
  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3973;
      5'd2:  v = 16'd7719;
      5'd3:  v = 16'd11262;
      5'd4:  v = 16'd14624;
      5'd5:  v = 16'd17821;
      5'd6:  v = 16'd20870;
      5'd7:  v = 16'd23783;
      5'd8:  v = 16'd26573;
      5'd9:  v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41196;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [16:0] clamp_out(input logic signed [23:0] v);
    logic signed [16:0] r;
    if (v < 24'(OUT_MIN)) begin
      r = 17'(OUT_MIN);
    end else if (v > 24'(OUT_MAX)) begin
      r = 17'(OUT_MAX);
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/ntc_if.sv]
// Interfaces: sample input channel and temperature result channel.
`default_nettype none
interface ntc_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ntc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] temperature_centi;
  logic [1:0]         fault;
  modport source (output valid, output temperature_centi, output fault, input ready);
  modport sink   (input valid, input temperature_centi, input fault, output ready);
endinterface
`default_nettype wire

[rtl/ntc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module ntc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ntc_pkg::div_req_t req,
  output logic                   done,
  output logic [ntc_pkg::DIV_W-1:0] quo
);
  logic [ntc_pkg::DIV_W-1:0]     rem_r, quo_r, den_r;
  logic [ntc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [ntc_pkg::DIV_W:0]       trial, diff;
  logic                          qbit;

  always_comb begin
    trial = {rem_r, quo_r[ntc_pkg::DIV_W-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ntc_pkg::DIV_CNT_W'(ntc_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ntc_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[ntc_pkg::DIV_W-1:0] : trial[ntc_pkg::DIV_W-1:0];
      quo_r <= {quo_r[ntc_pkg::DIV_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule
`default_nettype wire

[rtl/ntc_ln.sv]
// Natural log of a Q16.16 value: serial normalize, table lookup, interpolation.
`default_nettype none
module ntc_ln (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ntc_pkg::ln_req_t req,
  output logic                  busy,
  output logic signed [ntc_pkg::LNV_W-1:0] lnv
);
  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_MUL  = 2'd2;
  localparam logic [1:0] L_SUM  = 2'd3;
  localparam logic signed [22:0] LN2_S = 23'(ntc_pkg::LN2_Q16);

  logic [1:0]  st_r;
  logic [31:0] x_r;
  logic [4:0]  p_r;
  logic [15:0] lo_r;
  logic [38:0] prod_r;
  logic signed [ntc_pkg::LNV_W-1:0] lnv_r;

  logic [4:0]  idx;
  logic [15:0] lo, hi;
  logic [11:0] dif;
  logic signed [5:0]  pm16;
  logic signed [22:0] pterm, total;

  always_comb begin
    idx   = {1'b0, x_r[30:27]};
    lo    = ntc_pkg::ln_tab(idx);
    hi    = ntc_pkg::ln_tab(idx + 5'd1);
    dif   = 12'(hi - lo);
    pm16  = $signed({1'b0, p_r}) - 6'sd16;
    pterm = 23'(pm16) * LN2_S;
    total = pterm + $signed(23'(lo_r)) + $signed(23'(prod_r[38:27]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      case (st_r)
        L_IDLE: if (req.start) st_r <= L_NORM;
        L_NORM: if (x_r[31] || p_r == 5'd0) st_r <= L_MUL;
        L_MUL:  st_r <= L_SUM;
        L_SUM:  st_r <= L_IDLE;
        default: st_r <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      L_IDLE: begin
        x_r <= req.x;
        p_r <= 5'd31;
      end
      L_NORM: begin
        if (!(x_r[31] || p_r == 5'd0)) begin
          x_r <= {x_r[30:0], 1'b0};
          p_r <= p_r - 5'd1;
        end
      end
      L_MUL: begin
        lo_r   <= lo;
        prod_r <= 39'(dif) * 39'(x_r[26:0]);
      end
      L_SUM: lnv_r <= total[ntc_pkg::LNV_W-1:0];
      default: ;
    endcase
  end

  assign busy = (st_r != L_IDLE);
  assign lnv  = lnv_r;
endmodule
`default_nettype wire

[rtl/ntc_thermistor_temperature_core.sv]
// Top level: sample accumulation, conversion sequencer and result register.
//
//  channel | dir | payload                         | handshake
//  in_ch   | in  | adc_sample[9:0]                 | valid/ready
//  out_ch  | out | temperature_centi[16:0], fault  | valid/ready
//  cfg     | in  | cfg_addr[1:0], cfg_wdata[14:0]  | cfg_we
//
// Samples are taken one per cycle while in_ch.ready is high; the tenth of a group
// starts a conversion unless the group sum is zero or full scale. A conversion
// runs four passes of the serial divider for a Kelvin or Celsius result,
// Fahrenheit adds a fifth pass, and a nonpositive 1/T ends after three passes.
// The log unit overlaps the second pass.
// Fault results appear the cycle after the tenth sample. While converting, or
// while a result waits and the next sample would close a group, in_ch.ready is low.
// rst_n is synchronous; it clears the accumulator and loads register defaults.
`default_nettype none
module ntc_thermistor_temperature_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ntc_in_if.sink           in_ch,
  ntc_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [14:0] cfg_wdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RAT  = 3'd1;
  localparam logic [2:0] S_T0   = 3'd2;
  localparam logic [2:0] S_LNW  = 3'd3;
  localparam logic [2:0] S_BD   = 3'd4;
  localparam logic [2:0] S_TK   = 3'd5;
  localparam logic [2:0] S_F    = 3'd6;
  localparam int W = ntc_pkg::DIV_W;
  localparam logic [W-1:0] HUNDRED_Q32 = W'(100) << 32;

  logic [13:0]        beta_r;
  logic signed [14:0] t0_r;
  logic [1:0]         unit_r;
  logic [ntc_pkg::SUM_W-1:0] sum_r;
  logic [ntc_pkg::CNT_W-1:0] cnt_r;
  logic [2:0]         st_r;
  logic [W-1:0]       inv_t0_r;
  logic               neg_r;
  logic               out_valid_r;
  logic signed [16:0] out_temp_r;
  logic [1:0]         out_fault_r;

  ntc_pkg::div_req_t  div_req_r;
  ntc_pkg::ln_req_t   ln_req_r;
  logic               div_done, ln_busy;
  logic [W-1:0]       quo;
  logic signed [ntc_pkg::LNV_W-1:0] lnv;

  logic               in_acc, last;
  logic [ntc_pkg::SUM_W-1:0] sum_nxt;
  logic [31:0]        ratio;
  logic signed [17:0] den0_s;
  logic [W-1:0]       den0;
  logic [ntc_pkg::LNV_W-1:0] ln_mag;
  logic signed [W+1:0] inv_t;
  logic [W-1:0]       dval;
  logic [17:0]        tkc;
  logic signed [18:0] tc;
  logic signed [22:0] v9;
  logic [21:0]        v9_mag;
  logic signed [23:0] fval;

  ntc_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req_r),
    .done(div_done), .quo(quo)
  );

  ntc_ln u_ln (
    .clk(clk), .rst_n(rst_n), .req(ln_req_r), .busy(ln_busy), .lnv(lnv)
  );

  assign last        = (cnt_r == ntc_pkg::CNT_W'(ntc_pkg::SAMPLES - 1));
  assign in_ch.ready = (st_r == S_IDLE) && !(last && out_valid_r);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign sum_nxt     = sum_r + ntc_pkg::SUM_W'(in_ch.adc_sample);

  always_comb begin
    ratio  = (|quo[W-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
    if (ratio == 32'd0) ratio = 32'd1;
    den0_s = 18'(t0_r) + 18'sd27315;
    den0   = W'(unsigned'(den0_s));
    ln_mag = lnv[ntc_pkg::LNV_W-1] ? ntc_pkg::LNV_W'(-lnv) : ntc_pkg::LNV_W'(lnv);
    inv_t  = neg_r ? $signed({2'b00, inv_t0_r}) - $signed({2'b00, quo})
                   : $signed({2'b00, inv_t0_r}) + $signed({2'b00, quo});
    dval   = inv_t[W-1:0];
    tkc    = (|quo[W-1:18]) ? 18'h3FFFF : quo[17:0];
    tc     = $signed({1'b0, tkc}) - 19'sd27315;
    v9     = 23'(tc) * 23'sd9;
    v9_mag = v9[22] ? 22'(-v9) : 22'(v9);
    fval   = (neg_r ? -$signed({2'b00, quo[21:0]}) : $signed({2'b00, quo[21:0]}))
             + 24'sd3200;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= 14'd3380;
      t0_r   <= 15'sd2500;
      unit_r <= ntc_pkg::UNIT_CELSIUS;
    end else if (cfg_we) begin
      case (cfg_addr)
        ntc_pkg::CFG_BETA: beta_r <= cfg_wdata[13:0];
        ntc_pkg::CFG_T0:   t0_r   <= $signed(cfg_wdata);
        ntc_pkg::CFG_UNIT: unit_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= S_IDLE;
      sum_r           <= '0;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
      ln_req_r.start  <= 1'b0;
    end else begin
      div_req_r.start <= 1'b0;
      ln_req_r.start  <= 1'b0;
      if (out_ch.ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            if (last) begin
              sum_r <= '0;
              cnt_r <= '0;
              if (sum_nxt == '0) begin
                out_valid_r <= 1'b1;
                out_temp_r  <= '0;
                out_fault_r <= ntc_pkg::FAULT_ZERO;
              end else if (sum_nxt >= ntc_pkg::SUM_W'(ntc_pkg::FULL_SUM)) begin
                out_valid_r <= 1'b1;
                out_temp_r  <= '0;
                out_fault_r <= ntc_pkg::FAULT_FULL;
              end else begin
                div_req_r.start <= 1'b1;
                div_req_r.num   <= W'(ntc_pkg::SUM_W'(ntc_pkg::FULL_SUM) - sum_nxt) << 16;
                div_req_r.den   <= W'(sum_nxt);
                st_r            <= S_RAT;
              end
            end else begin
              sum_r <= sum_nxt;
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_RAT: if (div_done) begin
          ln_req_r.start  <= 1'b1;
          ln_req_r.x      <= ratio;
          div_req_r.start <= 1'b1;
          div_req_r.num   <= HUNDRED_Q32 + (den0 >> 1);
          div_req_r.den   <= den0;
          st_r            <= S_T0;
        end
        S_T0: if (div_done) begin
          inv_t0_r <= quo;
          st_r     <= S_LNW;
        end
        S_LNW: if (!ln_busy) begin
          neg_r           <= lnv[ntc_pkg::LNV_W-1];
          div_req_r.start <= 1'b1;
          div_req_r.num   <= W'(ln_mag) << 16;
          div_req_r.den   <= (beta_r == 14'd0) ? W'(1) : W'(beta_r);
          st_r            <= S_BD;
        end
        S_BD: if (div_done) begin
          if (inv_t <= 0) begin
            out_valid_r <= 1'b1;
            out_temp_r  <= 17'(ntc_pkg::OUT_MAX);
            out_fault_r <= ntc_pkg::FAULT_NONE;
            st_r        <= S_IDLE;
          end else begin
            div_req_r.start <= 1'b1;
            div_req_r.num   <= HUNDRED_Q32 + (dval >> 1);
            div_req_r.den   <= dval;
            st_r            <= S_TK;
          end
        end
        S_TK: if (div_done) begin
          if (unit_r == ntc_pkg::UNIT_KELVIN || unit_r == ntc_pkg::UNIT_CELSIUS) begin
            out_valid_r <= 1'b1;
            out_temp_r  <= ntc_pkg::clamp_out((unit_r == ntc_pkg::UNIT_KELVIN)
                                              ? 24'($signed({1'b0, tkc})) : 24'(tc));
            out_fault_r <= ntc_pkg::FAULT_NONE;
            st_r        <= S_IDLE;
          end else begin
            // Fahrenheit: round(9*C/5) with halves away from zero
            neg_r           <= v9[22];
            div_req_r.start <= 1'b1;
            div_req_r.num   <= W'(v9_mag) + W'(2);
            div_req_r.den   <= W'(5);
            st_r            <= S_F;
          end
        end
        S_F: if (div_done) begin
          out_valid_r <= 1'b1;
          out_temp_r  <= ntc_pkg::clamp_out(fval);
          out_fault_r <= ntc_pkg::FAULT_NONE;
          st_r        <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.fault             = out_fault_r;
endmodule
`default_nettype wire

[rtl/ntc_chk.sv]
// Port-level checker for the thermistor core, bound to the top level.
`default_nettype none
module ntc_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [16:0] out_temp,
  input wire logic [1:0]        out_fault
);
  // a fault result carries a zero temperature
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault != ntc_pkg::FAULT_NONE) |-> (out_temp == 17'sd0))
    else $error("fault result with nonzero temperature");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp >= -17'sd50000 && out_temp <= 17'sd60000))
    else $error("temperature outside saturation range");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fault != 2'd3))
    else $error("undefined fault code");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_temp) && $stable(out_fault)))
    else $error("stalled result changed");
endmodule

bind ntc_thermistor_temperature_core ntc_chk u_ntc_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_temp(out_ch.temperature_centi), .out_fault(out_ch.fault)
);
`default_nettype wire

[sim/tb_ntc_thermistor_temperature_core.sv]
// Testbench for the thermistor temperature core: random sample groups, predicted results.
`default_nettype none
module tb_ntc_thermistor_temperature_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] UNIT_FAHRENHEIT = 2'd2;
  localparam logic [1:0] UNIT_SPARE      = 2'd3;
  localparam logic [1:0] CFG_UNUSED      = 2'd3;
  localparam int GROUP      = 10;
  localparam int SETTLE     = 400;
  localparam int HOLD_LEN   = 2000;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [16:0] temp;
    logic [1:0]         fault;
  } reading_t;

  class temp_scoreboard;
    int unsigned        acc_sum;
    int unsigned        acc_count;
    int unsigned        beta;
    int                 t0_centi;
    logic [1:0]         unit;
    reading_t           pending[$];
    int                 mismatches;
    int                 ln_steps[17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
                                         26573, 29248, 31818, 34292, 36675, 38975, 41196,
                                         43345, 45426};

    function new();
      acc_sum = 0; acc_count = 0; beta = 3380; t0_centi = 2500;
      unit = ntc_pkg::UNIT_CELSIUS;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] val);
      case (idx)
        ntc_pkg::CFG_BETA: beta = val[13:0];
        ntc_pkg::CFG_T0:   t0_centi = $signed(val);
        ntc_pkg::CFG_UNIT: unit = val[1:0];
        default: ;
      endcase
    endfunction

    // Q16.16 in, Q8.16 out: power-of-two split, table with linear interpolation
    function longint log_q16(logic [31:0] x);
      int p;
      logic [31:0] mant;
      int idx;
      longint rem, lo, diff;
      p = 31;
      while (p > 0 && !x[p]) p--;
      mant = x << (31 - p);
      idx = mant[30:27];
      rem = mant[26:0];
      lo = ln_steps[idx];
      diff = ln_steps[idx + 1] - lo;
      return longint'(p - 16) * ntc_pkg::LN2_Q16 + lo + ((diff * rem) >>> 27);
    endfunction

    function longint limit(longint v);
      if (v < ntc_pkg::OUT_MIN) return ntc_pkg::OUT_MIN;
      if (v > ntc_pkg::OUT_MAX) return ntc_pkg::OUT_MAX;
      return v;
    endfunction

    function longint temperature(longint s);
      longint ratio, lnv, den0, inv_t0, b, inv_t, tk, tc, v, f;
      ratio = ((longint'(ntc_pkg::FULL_SUM) - s) << 16) / s;
      if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
      if (ratio == 0) ratio = 1;
      lnv = log_q16(ratio[31:0]);
      den0 = t0_centi + ntc_pkg::KELVIN_CENT;
      inv_t0 = ((longint'(100) << 32) + den0 / 2) / den0;
      b = (beta == 0) ? 1 : beta;
      inv_t = inv_t0 + (lnv * 65536) / b;
      if (inv_t <= 0) return ntc_pkg::OUT_MAX;
      tk = ((longint'(100) << 32) + inv_t / 2) / inv_t;
      tc = tk - ntc_pkg::KELVIN_CENT;
      if (unit == ntc_pkg::UNIT_KELVIN) return limit(tk);
      if (unit == ntc_pkg::UNIT_CELSIUS) return limit(tc);
      v = tc * 9;
      f = (v >= 0) ? (v + 2) / 5 : -((-v + 2) / 5);
      return limit(f + 3200);
    endfunction

    function void note_sample(logic [9:0] s);
      reading_t r;
      acc_sum += s;
      acc_count++;
      if (acc_count < GROUP) return;
      r.temp = '0;
      r.fault = ntc_pkg::FAULT_NONE;
      if (acc_sum == 0) r.fault = ntc_pkg::FAULT_ZERO;
      else if (acc_sum >= ntc_pkg::FULL_SUM) r.fault = ntc_pkg::FAULT_FULL;
      else r.temp = 17'(temperature(acc_sum));
      pending.push_back(r);
      acc_sum = 0;
      acc_count = 0;
    endfunction

    function void check(logic signed [16:0] temp, logic [1:0] fault);
      reading_t r;
      if (pending.size() == 0) begin
        $error("unexpected result: temperature_centi %0d fault %0d", temp, fault);
        mismatches++;
        return;
      end
      r = pending.pop_front();
      if (temp !== r.temp) begin
        $error("temperature_centi: expected %0d, got %0d", r.temp, temp);
        mismatches++;
      end
      if (fault !== r.fault) begin
        $error("fault: expected %0d, got %0d", r.fault, fault);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [14:0] cfg_wdata;

  ntc_in_if  in_ch();
  ntc_out_if out_ch();

  ntc_thermistor_temperature_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  temp_scoreboard sb = new();
  bit calm;
  bit hold_request;
  int hold_left;
  int quiet_cycles;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check, random stall, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check(out_ch.temperature_centi, out_ch.fault);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_ntc_thermistor_temperature_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_sample(logic [9:0] s);
    if (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic send_group(int mode);
    int center;
    center = $urandom_range(1023);
    for (int i = 0; i < GROUP; i++) begin
      case (mode)
        0: send_sample(10'($urandom_range(1023)));
        1: send_sample(10'(center + $urandom_range(16) - 8));
        2: send_sample($urandom_range(1) ? 10'($urandom_range(3))
                                         : 10'($urandom_range(1023, 1020)));
        default: send_sample(10'(center));
      endcase
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  int unsigned beta_set[8]  = '{3380, 1000, 10000, 0, 16383, 4250, 1000, 10000};
  int          t0_set[8]    = '{2500, -4000, 15000, -16384, 16383, 0, 15000, -4000};
  logic [1:0]  unit_set[8]  = '{ntc_pkg::UNIT_CELSIUS, ntc_pkg::UNIT_KELVIN,
                                UNIT_FAHRENHEIT, UNIT_SPARE, ntc_pkg::UNIT_CELSIUS,
                                UNIT_FAHRENHEIT, ntc_pkg::UNIT_CELSIUS,
                                ntc_pkg::UNIT_KELVIN};

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all zero, full scale, tiny mean, mixed near full scale
    for (int i = 0; i < GROUP; i++) send_sample(10'd0);
    for (int i = 0; i < GROUP; i++) send_sample(10'd1023);
    for (int i = 0; i < GROUP; i++) send_sample(i == 0 ? 10'd1 : 10'd0);
    for (int i = 0; i < GROUP; i++) send_sample(i == 0 ? 10'd1022 : 10'd1023);
    drain();
    write_reg(CFG_UNUSED, 15'h7FFF);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ntc_pkg::CFG_BETA, 15'(beta_set[ph]));
      write_reg(ntc_pkg::CFG_T0, 15'(t0_set[ph]));
      write_reg(ntc_pkg::CFG_UNIT, 15'(unit_set[ph]));
      calm = (ph == 2);
      if (ph == 3) hold_request = 1'b1;
      for (int g = 0; g < 24; g++) send_group($urandom_range(3));
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("tb_ntc_thermistor_temperature_core passed");
    end else begin
      $display("tb_ntc_thermistor_temperature_core failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
